// ===== rtl/core/bfbp_pkg.sv =====
// ----------------------------------------------------------------------------
// bfbp_pkg
// Shared constants for the best-fit bin packing core: status codes,
// register map and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package bfbp_pkg;

  // fixed field widths of the stream and register payloads
  localparam int unsigned SIZE_FIELD_W = 16;
  localparam int unsigned BIN_FIELD_W  = 6;
  localparam int unsigned CNT_FIELD_W  = 7;
  localparam int unsigned STATUS_W     = 2;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_ADDR_BIN_CAPACITY = 3'd0;
  localparam logic [31:0] CAP_RESET = 32'd100;

  typedef logic [STATUS_W-1:0] status_t;

  // result status codes
  localparam status_t STATUS_PLACED  = 2'd0;
  localparam status_t STATUS_REJECT  = 2'd1;
  localparam status_t STATUS_EXHAUST = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/bfbp_apb_regs.sv =====
// ----------------------------------------------------------------------------
// bfbp_apb_regs
// APB-style register file holding the bin capacity, masked to the
// configured size width.
// ----------------------------------------------------------------------------
`default_nettype none

module bfbp_apb_regs #(
  parameter int unsigned SIZE_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bfbp_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [bfbp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [bfbp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready,
  output logic      [SIZE_BITS-1:0]           capacity
);
  import bfbp_pkg::*;

  logic [SIZE_BITS-1:0] cap_r;
  logic [SIZE_BITS-1:0] cap_nxt;
  logic [31:0]          wdata_ext;
  logic                 reg_hit;
  logic                 wr_en;

  // only the low field bits are kept, then masked to the size width
  assign wdata_ext = {16'b0, pwdata[SIZE_FIELD_W-1:0]};
  assign reg_hit   = (paddr[CFG_ADDR_W-1] == REG_ADDR_BIN_CAPACITY[CFG_ADDR_W-1]);
  assign wr_en     = psel && penable && pwrite && pready && reg_hit;
  assign cap_nxt   = wr_en ? wdata_ext[SIZE_BITS-1:0] : cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET[SIZE_BITS-1:0];
    end else begin
      cap_r <= cap_nxt;
    end
  end

  // read-back
  always_comb begin
    if (reg_hit) begin
      prdata = CFG_DATA_W'(cap_r);
    end else begin
      prdata = '0;
    end
  end

  assign pready   = 1'b1;
  assign capacity = cap_r;

endmodule

`default_nettype wire

// ===== rtl/core/best_fit_bin_packing_core.sv =====
// ----------------------------------------------------------------------------
// best_fit_bin_packing_core
// Online best-fit bin packing over a store of open-bin remainders.
// ----------------------------------------------------------------------------
// Each accepted beat places one item in the open bin with the smallest
// remainder that still holds it (lowest index on a tie), or opens a new bin
// at the configured capacity, or reports exhaustion when the store is full.
// A set flag on the beat empties all bins first. The remainders sit in a
// single-port memory that is scanned one entry per cycle through one shared
// compare unit, followed by a write-back step and a result step. A rejected
// item (size zero or above capacity) skips the scan and write-back and goes
// straight to the result step. The input is not ready while an item is being
// worked on; the result sits in an output register until taken.
`default_nettype none

module best_fit_bin_packing_core #(
  parameter int unsigned MAX_BINS  = 64,
  parameter int unsigned SIZE_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // tdata: item_size[15:0]
  input  wire logic [15:0]                     in_tdata,
  // tuser: first_of_set[0]
  input  wire logic [0:0]                      in_tuser,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // tdata: bin_index[5:0], bins_in_use[12:6], zero pad[15:13]
  output logic [15:0]                          out_tdata,
  // tuser: opened_new[0], status[2:1]
  output logic [2:0]                           out_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [bfbp_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [bfbp_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [bfbp_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                 cfg_pready
);
  import bfbp_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_BINS);
  localparam int unsigned CNT_W = $clog2(MAX_BINS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BINS);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [SIZE_BITS-1:0] capacity;
  logic [SIZE_BITS-1:0] size_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     scan_idx_r;
  logic                 rd_pend_r;
  logic [IDX_W-1:0]     rd_idx_r;
  logic                 found_r;
  logic [SIZE_BITS-1:0] best_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic [IDX_W-1:0]     chosen_r;
  logic                 opened_r;
  status_t              status_r;
  logic                 out_valid_r;
  logic [BIN_FIELD_W-1:0] out_bin_r;
  logic [CNT_FIELD_W-1:0] out_cnt_r;
  logic                 out_open_r;
  status_t              out_status_r;

  logic [SIZE_BITS-1:0] rem_mem [MAX_BINS];
  logic [SIZE_BITS-1:0] mem_q;

  logic [31:0]          size_ext;
  logic [SIZE_BITS-1:0] size_in;
  logic                 in_acc;
  logic                 reject;
  logic                 issue;
  logic                 hit;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [SIZE_BITS-1:0] sub_a;
  logic [SIZE_BITS-1:0] wr_data;
  logic                 out_load;
  logic [31:0]          chosen_ext;
  logic [31:0]          count_ext;

  // configuration registers
  bfbp_apb_regs #(
    .SIZE_BITS (SIZE_BITS)
  ) u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .pready   (cfg_pready),
    .capacity (capacity)
  );

  // input decode and rejection check
  assign size_ext  = {16'b0, in_tdata[SIZE_FIELD_W-1:0]};
  assign size_in   = size_ext[SIZE_BITS-1:0];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign reject    = (size_in == '0) || (size_in > capacity);

  // scan: one read issued per cycle, compared in the cycle after
  assign issue = (state_r == S_SCAN) && (scan_idx_r < count_r);
  assign hit   = rd_pend_r && (mem_q >= size_r) && (!found_r || (mem_q < best_r));

  // shared subtractor for the write-back
  assign sub_a   = found_r ? best_r : capacity;
  assign wr_data = sub_a - size_r;
  assign wr_addr = found_r ? best_idx_r : count_r[IDX_W-1:0];
  assign wr_en   = (state_r == S_DECIDE) && (found_r || (count_r < MAX_CNT));

  // remainder memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rem_mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      mem_q <= rem_mem[scan_idx_r[IDX_W-1:0]];
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = reject ? S_RESULT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (!issue && !rd_pend_r) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_load = (state_r == S_RESULT) && (!out_valid_r || out_tready);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_pend_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= issue;
      if (in_acc) begin
        found_r <= 1'b0;
        if (in_tuser[0]) begin
          count_r <= '0;
        end
      end else if (hit) begin
        found_r <= 1'b1;
      end
      if (wr_en && !found_r) begin
        count_r <= CNT_W'(count_r + 1'b1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item and scan datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      size_r     <= size_in;
      scan_idx_r <= '0;
      chosen_r   <= '0;
      opened_r   <= 1'b0;
      status_r   <= reject ? STATUS_REJECT : STATUS_PLACED;
    end
    if (issue) begin
      scan_idx_r <= CNT_W'(scan_idx_r + 1'b1);
      rd_idx_r   <= scan_idx_r[IDX_W-1:0];
    end
    if (hit) begin
      best_r     <= mem_q;
      best_idx_r <= rd_idx_r;
    end
    if (state_r == S_DECIDE) begin
      if (found_r) begin
        chosen_r <= best_idx_r;
      end else if (count_r < MAX_CNT) begin
        chosen_r <= count_r[IDX_W-1:0];
        opened_r <= 1'b1;
      end else begin
        status_r <= STATUS_EXHAUST;
      end
    end
  end

  // result register
  assign chosen_ext = 32'(chosen_r);
  assign count_ext  = 32'(count_r);

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bin_r    <= chosen_ext[BIN_FIELD_W-1:0];
      out_cnt_r    <= count_ext[CNT_FIELD_W-1:0];
      out_open_r   <= opened_r;
      out_status_r <= status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b0, out_cnt_r, out_bin_r};
  assign out_tuser  = {out_status_r, out_open_r};

`ifndef SYNTH
  // bin count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("open bin count above store depth");

  // a candidate bin always holds the item
  a_best_fits: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> (best_r >= size_r))
    else $error("chosen remainder smaller than item");

  // reads are in flight only during the scan
  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == S_SCAN))
    else $error("memory read outside scan");

  // opening a bin bumps the count by one
  a_open_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !found_r) |=> (count_r == CNT_W'($past(count_r) + 1'b1)))
    else $error("new bin not counted");

  // an opened bin is always a placed item
  a_open_placed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_open_r) |-> (out_status_r == STATUS_PLACED))
    else $error("opened bin with non-placed status");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_best_fit_bin_packing_core.sv =====
// ----------------------------------------------------------------------------
// tb_best_fit_bin_packing_core
// Self-checking bench for the best-fit bin packing core: a short scripted
// pass over the corner cases, then random packing sets under changing
// capacities, each result compared against a best-fit placement predictor.
// ----------------------------------------------------------------------------

module tb_best_fit_bin_packing_core;

  import bfbp_pkg::*;

  localparam int unsigned NUM_BINS      = 64;
  localparam int          SETTLE_CYCLES = NUM_BINS + 16;
  localparam int          STALL_LIMIT   = 4000;
  localparam int          REGIME_ITEMS  = 645;

  typedef struct packed {
    logic [5:0] bin;
    logic       opened;
    logic [6:0] count;
    status_t    status;
  } placement_t;

  typedef enum logic {ROW_ITEM, ROW_CAP} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [15:0] value;
    logic        first;
    logic        typed;
    placement_t  want;
  } script_row_t;

  logic        clk;
  logic        rst_n;
  logic [15:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic        cfg_pready;

  // predictor state
  logic [15:0] capacity;
  logic [15:0] bin_room [NUM_BINS];
  int          bins_open;

  placement_t  placements_due [$];
  script_row_t script_rows [$];
  int          fault_cnt;
  int          stall_cycles;
  int          send_idle_pct;
  int          take_idle_pct;

  best_fit_bin_packing_core #(
    .MAX_BINS  (NUM_BINS),
    .SIZE_BITS (16)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // best-fit placement of one item, updating the predicted bin state
  function automatic placement_t place_item(logic [15:0] size, logic first);
    placement_t p;
    logic       found;
    logic [15:0] best_room;
    int         best_bin;
    int         b;
    p = '0;
    found = 1'b0;
    best_room = '0;
    best_bin = 0;
    if (first) bins_open = 0;
    if (size == 16'd0 || size > capacity) begin
      p.status = STATUS_REJECT;
    end else begin
      p.status = STATUS_PLACED;
      // strict compare keeps the lowest index on equal room
      for (b = 0; b < bins_open; b++) begin
        if (bin_room[b] >= size && (!found || bin_room[b] < best_room)) begin
          found = 1'b1;
          best_room = bin_room[b];
          best_bin = b;
        end
      end
      if (found) begin
        bin_room[best_bin] = best_room - size;
        p.bin = 6'(best_bin);
      end else if (bins_open < NUM_BINS) begin
        bin_room[bins_open] = capacity - size;
        p.bin = 6'(bins_open);
        p.opened = 1'b1;
        bins_open++;
      end else begin
        p.status = STATUS_EXHAUST;
      end
    end
    p.count = 7'(bins_open);
    return p;
  endfunction

  function automatic void add_row(row_kind_t kind, logic [15:0] value, logic first,
                                  logic typed, logic [5:0] bin, logic opened,
                                  logic [6:0] count, status_t status);
    script_row_t r;
    r.kind = kind;
    r.value = value;
    r.first = first;
    r.typed = typed;
    r.want = '{bin, opened, count, status};
    script_rows.insert(script_rows.size(), r);
  endfunction

  // one item beat, with a random gap in front of it
  task automatic send_item(input logic [15:0] size, input logic first,
                           input logic typed, input placement_t want);
    placement_t due;
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tdata  <= size;
    in_tuser  <= first;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    due = place_item(size, first);
    placements_due.insert(placements_due.size(), typed ? want : due);
  endtask

  // hold off the sender until every result is back and the core is idle
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (placements_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write of the capacity register, junk in the unused upper bits
  task automatic write_capacity(input logic [15:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= REG_ADDR_BIN_CAPACITY;
    cfg_pwdata  <= {16'($urandom), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    capacity = value;
  endtask

  function automatic logic [15:0] pick_capacity();
    int r;
    r = $urandom_range(99);
    if (r < 3)  return 16'd0;
    if (r < 13) return 16'd1;
    if (r < 23) return 16'hFFFF;
    if (r < 33) return 16'($urandom_range(2, 8));
    if (r < 63) return 16'($urandom_range(10, 200));
    return 16'($urandom_range(2, 65535));
  endfunction

  // deep sets use items above half the capacity so every one needs its own bin
  function automatic logic [15:0] pick_size(bit deep);
    int c;
    int r;
    c = capacity;
    r = $urandom_range(99);
    if (c == 0) return 16'($urandom);
    if (r < 3) return 16'd0;
    if (r < 6) return 16'($urandom);
    if (r < 8 && c < 65535) return 16'($urandom_range(c + 1, 65535));
    if (deep) return 16'($urandom_range(c / 2 + 1, c));
    if (r < 55) return 16'($urandom_range(1, c));
    return 16'($urandom_range(1, (c + 3) / 4));
  endfunction

  // random packing sets, a fresh capacity per phase
  task automatic run_regime(input int items);
    int          left;
    int          phase_items;
    int          set_len;
    int          n;
    logic        first;
    bit          deep;
    left = items;
    while (left > 0) begin
      settle();
      write_capacity(pick_capacity());
      phase_items = $urandom_range(60, 200);
      while (phase_items > 0 && left > 0) begin
        deep = ($urandom_range(99) < 20);
        set_len = deep ? $urandom_range(72, 100) : $urandom_range(1, 30);
        // now and then the old set carries on across a capacity change
        first = ($urandom_range(9) != 0);
        for (n = 0; n < set_len && left > 0; n++) begin
          send_item(pick_size(deep), first, 1'b0, '0);
          first = ($urandom_range(99) < 3);
          phase_items--;
          left--;
        end
        if ($urandom_range(99) < 5) settle();
      end
    end
  endtask

  // receiver side back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= take_idle_pct);
  end

  task automatic report(input string what, input placement_t want, input placement_t got);
    fault_cnt++;
    if (fault_cnt <= 10) begin
      $display("%s: want bin=%0d new=%0d count=%0d status=%0d",
               what, want.bin, want.opened, want.count, want.status);
      $display("  got bin=%0d new=%0d count=%0d status=%0d",
               got.bin, got.opened, got.count, got.status);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    placement_t got;
    placement_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[5:0], out_tuser[0], out_tdata[12:6], out_tuser[2:1]};
      if (placements_due.size() == 0) begin
        report("result beat with nothing due", '0, got);
      end else begin
        want = placements_due.pop_front();
        if (got.bin != want.bin || got.opened != want.opened ||
            got.count != want.count || got.status != want.status) begin
          report("result mismatch", want, got);
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    script_row_t row;
    int          i;
    rst_n       <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    in_tvalid   <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    capacity = 16'(CAP_RESET);
    bins_open = 0;
    for (i = 0; i < NUM_BINS; i++) bin_room[i] = '0;
    send_idle_pct = 27;
    take_idle_pct = 51;

    // scripted corner cases, capacity 100 out of reset
    //      kind      value     first typed bin  new cnt  status
    add_row(ROW_ITEM, 16'd0,     1'b1, 1'b1, 6'd0, 1'b0, 7'd0, STATUS_REJECT);
    add_row(ROW_ITEM, 16'd101,   1'b0, 1'b1, 6'd0, 1'b0, 7'd0, STATUS_REJECT);
    add_row(ROW_ITEM, 16'hFFFF,  1'b0, 1'b1, 6'd0, 1'b0, 7'd0, STATUS_REJECT);
    add_row(ROW_ITEM, 16'd100,   1'b0, 1'b1, 6'd0, 1'b1, 7'd1, STATUS_PLACED);
    add_row(ROW_ITEM, 16'd60,    1'b0, 1'b1, 6'd1, 1'b1, 7'd2, STATUS_PLACED);
    add_row(ROW_ITEM, 16'd30,    1'b0, 1'b0, 6'd0, 1'b0, 7'd0, STATUS_PLACED);
    add_row(ROW_ITEM, 16'd10,    1'b0, 1'b0, 6'd0, 1'b0, 7'd0, STATUS_PLACED);
    add_row(ROW_ITEM, 16'd50,    1'b0, 1'b0, 6'd0, 1'b0, 7'd0, STATUS_PLACED);
    add_row(ROW_ITEM, 16'd70,    1'b1, 1'b1, 6'd0, 1'b1, 7'd1, STATUS_PLACED);
    // equal room in two bins
    add_row(ROW_ITEM, 16'd70,    1'b0, 1'b0, 6'd0, 1'b0, 7'd0, STATUS_PLACED);
    add_row(ROW_ITEM, 16'd20,    1'b0, 1'b0, 6'd0, 1'b0, 7'd0, STATUS_PLACED);
    // set flag on a rejected item still empties the bins
    add_row(ROW_ITEM, 16'd0,     1'b1, 1'b1, 6'd0, 1'b0, 7'd0, STATUS_REJECT);
    add_row(ROW_ITEM, 16'd1,     1'b0, 1'b1, 6'd0, 1'b1, 7'd1, STATUS_PLACED);
    // capacity raised in the middle of a set
    add_row(ROW_CAP,  16'hFFFF,  1'b0, 1'b0, 6'd0, 1'b0, 7'd0, STATUS_PLACED);
    add_row(ROW_ITEM, 16'hFFFF,  1'b0, 1'b0, 6'd0, 1'b0, 7'd0, STATUS_PLACED);
    add_row(ROW_ITEM, 16'd40000, 1'b0, 1'b0, 6'd0, 1'b0, 7'd0, STATUS_PLACED);
    add_row(ROW_ITEM, 16'd99,    1'b0, 1'b0, 6'd0, 1'b0, 7'd0, STATUS_PLACED);
    // zero capacity rejects everything
    add_row(ROW_CAP,  16'd0,     1'b0, 1'b0, 6'd0, 1'b0, 7'd0, STATUS_PLACED);
    add_row(ROW_ITEM, 16'd1,     1'b1, 1'b1, 6'd0, 1'b0, 7'd0, STATUS_REJECT);
    add_row(ROW_ITEM, 16'hFFFF,  1'b0, 1'b1, 6'd0, 1'b0, 7'd0, STATUS_REJECT);
    // smallest capacity
    add_row(ROW_CAP,  16'd1,     1'b0, 1'b0, 6'd0, 1'b0, 7'd0, STATUS_PLACED);
    add_row(ROW_ITEM, 16'd1,     1'b1, 1'b1, 6'd0, 1'b1, 7'd1, STATUS_PLACED);
    add_row(ROW_ITEM, 16'd1,     1'b0, 1'b1, 6'd1, 1'b1, 7'd2, STATUS_PLACED);
    add_row(ROW_ITEM, 16'd2,     1'b0, 1'b1, 6'd0, 1'b0, 7'd2, STATUS_REJECT);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script_rows[i]) begin
      row = script_rows[i];
      if (row.kind == ROW_CAP) begin
        settle();
        write_capacity(row.value);
      end else begin
        send_item(row.value, row.first, row.typed, row.want);
      end
    end

    // random sets under three idling patterns
    run_regime(REGIME_ITEMS);
    send_idle_pct = 51;
    take_idle_pct = 27;
    run_regime(REGIME_ITEMS);
    send_idle_pct = 0;
    take_idle_pct = 0;
    run_regime(REGIME_ITEMS);

    settle();
    if (fault_cnt == 0 && placements_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
